FILE: design/ssba_pkg.sv
// ----------------------------------------------------------------------------
// ssba_pkg
// shared types and constants of the swap slot bitmap allocator
// ----------------------------------------------------------------------------
package ssba_pkg;

    // pool geometry
    localparam int NUM_SLOTS        = 1024;
    localparam int SECTORS_PER_SLOT = 8;
    localparam int WORD_BITS        = 64;
    localparam int MAP_WORDS        = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;

    // field and index widths
    localparam int SLOT_W   = 10;
    localparam int SECTOR_W = 32;
    localparam int COUNT_W  = 11;
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int WADDR_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SCAN_W   = $clog2(MAP_WORDS + 1);

    localparam logic [SECTOR_W-1:0] SECTOR_BASE_RESET = SECTOR_W'(8192);

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_RANGE   = 2'd2,
        STATUS_NOTUSED = 2'd3
    } status_t;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot_in;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot_out;
        logic [SECTOR_W-1:0] sector_out;
        logic [COUNT_W-1:0]  used_count;
    } out_item_t;

endpackage

FILE: design/ssba_find_free.sv
// ----------------------------------------------------------------------------
// ssba_find_free
// finds the lowest free slot of one bitmap word, optionally from a start bit
// ----------------------------------------------------------------------------
module ssba_find_free
(
    input  logic [ssba_pkg::WORD_BITS-1:0] word,
    input  logic                           use_start,
    input  logic [ssba_pkg::BIT_W-1:0]     start_bit,
    output logic                           found,
    output logic [ssba_pkg::BIT_W-1:0]     bit_idx
);

    logic [ssba_pkg::WORD_BITS-1:0] start_mask;
    logic [ssba_pkg::WORD_BITS-1:0] free_bits;

    always_comb
    begin
        start_mask = use_start ? ({ssba_pkg::WORD_BITS{1'b1}} << start_bit)
                               : {ssba_pkg::WORD_BITS{1'b1}};
        free_bits  = ~word & start_mask;
        found      = |free_bits;
        bit_idx    = '0;
        // priority from the top down so the lowest free bit wins
        for (int i = ssba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                bit_idx = ssba_pkg::BIT_W'(i);
            end
        end
    end

endmodule

FILE: design/swap_slot_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// next-fit swap slot allocator over a used-slot bitmap with count and hint
// ----------------------------------------------------------------------------
//
//  channel   signals                      direction  notes
//  --------  ---------------------------  ---------  --------------------------
//  request   in_valid, in_stall, in_item  in         cmd + slot to free
//  result    out_valid, out_stall, out_item out      status, slot, sector, count
//  config    cfg_valid, cfg_ready, cfg_data in       sector_base, always ready
//
//  allocate: read the hint word, then check one bitmap word per cycle
//  until a free bit turns up or the scan is back round at the hint word,
//  then the result; the single bitmap memory read port sets this rate
//  free: read word, check and write back, result, also when the slot is
//  already free; a full pool or an out-of-range slot goes straight to result
//  reset clears the count, hint and the per-word valid bits and loads the
//  sector base with 8192; no clearing pass, an invalid word reads as all free
//  in_stall is high while an item is at work; a stalled result sits in the
//  output register while the next item may already be accepted
//
module swap_slot_bitmap_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  ssba_pkg::in_item_t            in_item,

    output logic                          out_valid,
    input  logic                          out_stall,
    output ssba_pkg::out_item_t           out_item,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssba_pkg::SECTOR_W-1:0] cfg_data
);

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN     = 4'b0010,
        ST_FREE_CHK = 4'b0100,
        ST_RESP     = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [ssba_pkg::SECTOR_W-1:0] sector_base_reg;
    logic [ssba_pkg::COUNT_W-1:0]  used_total_reg, used_total_next;
    logic [ssba_pkg::SLOT_W-1:0]   search_hint_reg, search_hint_next;

    // bitmap memory, one valid bit per word
    logic [ssba_pkg::WORD_BITS-1:0] map_mem [ssba_pkg::MAP_WORDS];
    logic [ssba_pkg::MAP_WORDS-1:0] row_valid_reg;
    logic [ssba_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                           rd_valid_reg;
    logic [ssba_pkg::WADDR_W-1:0]   rd_addr;
    logic                           wr_en;
    logic [ssba_pkg::WADDR_W-1:0]   wr_addr;
    logic [ssba_pkg::WORD_BITS-1:0] wr_data;
    logic [ssba_pkg::WORD_BITS-1:0] cur_word;

    // scan bookkeeping
    logic [ssba_pkg::WADDR_W-1:0] chk_addr_reg, chk_addr_next;
    logic [ssba_pkg::WADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic [ssba_pkg::SCAN_W-1:0]  chk_cnt_reg, chk_cnt_next;

    // result being built
    ssba_pkg::status_t           res_status_reg, res_status_next;
    logic [ssba_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic                        res_alloc_reg, res_alloc_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    ssba_pkg::out_item_t out_item_reg, out_item_next;

    // find unit
    logic                       ff_found;
    logic [ssba_pkg::BIT_W-1:0] ff_bit;
    logic [ssba_pkg::SLOT_W-1:0] found_slot;
    logic [ssba_pkg::BIT_W-1:0] req_bit;

    logic in_fire;
    logic out_fire;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // a word never written since reset counts as all free
    assign cur_word   = rd_valid_reg ? rd_data_reg : '0;
    assign found_slot = ssba_pkg::SLOT_W'({chk_addr_reg, ff_bit});
    assign req_bit    = res_slot_reg[ssba_pkg::BIT_W-1:0];

    ssba_find_free u_find
    (
        .word      (cur_word),
        .use_start (chk_cnt_reg == '0),
        .start_bit (search_hint_reg[ssba_pkg::BIT_W-1:0]),
        .found     (ff_found),
        .bit_idx   (ff_bit)
    );

    function automatic logic [ssba_pkg::WADDR_W-1:0] next_waddr(
        input logic [ssba_pkg::WADDR_W-1:0] a
    );
        return (a == ssba_pkg::WADDR_W'(ssba_pkg::MAP_WORDS - 1)) ? '0 : a + 1'b1;
    endfunction

    always_comb
    begin
        state_next       = state_reg;
        used_total_next  = used_total_reg;
        search_hint_next = search_hint_reg;
        chk_addr_next    = chk_addr_reg;
        scan_addr_next   = scan_addr_reg;
        chk_cnt_next     = chk_cnt_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_alloc_next   = res_alloc_reg;
        out_valid_next   = out_valid_reg && !out_fire;
        out_item_next    = out_item_reg;
        rd_addr          = scan_addr_reg;
        wr_en            = 1'b0;
        wr_addr          = chk_addr_reg;
        wr_data          = cur_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_alloc_next = (in_item.cmd == ssba_pkg::CMD_ALLOC);
                    if (in_item.cmd == ssba_pkg::CMD_ALLOC)
                    begin
                        res_slot_next = '0;
                        if (used_total_reg >= ssba_pkg::COUNT_W'(ssba_pkg::NUM_SLOTS))
                        begin
                            res_status_next = ssba_pkg::STATUS_FULL;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            // start the scan at the hint word
                            rd_addr        = search_hint_reg[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_W];
                            chk_addr_next  = rd_addr;
                            scan_addr_next = next_waddr(rd_addr);
                            chk_cnt_next   = '0;
                            state_next     = ST_SCAN;
                        end
                    end
                    else
                    begin
                        res_slot_next = in_item.slot_in;
                        if (32'(in_item.slot_in) >= ssba_pkg::NUM_SLOTS)
                        begin
                            res_status_next = ssba_pkg::STATUS_RANGE;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            rd_addr       = in_item.slot_in[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_W];
                            chk_addr_next = rd_addr;
                            state_next    = ST_FREE_CHK;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // read of the next word overlaps the check of this one
                rd_addr = scan_addr_reg;
                if (ff_found)
                begin
                    wr_en            = 1'b1;
                    wr_data          = cur_word | (ssba_pkg::WORD_BITS'(1) << ff_bit);
                    used_total_next  = used_total_reg + 1'b1;
                    search_hint_next = (found_slot == ssba_pkg::SLOT_W'(ssba_pkg::NUM_SLOTS - 1))
                                       ? '0 : found_slot + 1'b1;
                    res_slot_next    = found_slot;
                    res_status_next  = ssba_pkg::STATUS_OK;
                    state_next       = ST_RESP;
                end
                else if (chk_cnt_reg == ssba_pkg::SCAN_W'(ssba_pkg::MAP_WORDS))
                begin
                    // wrapped back past the hint word with nothing free
                    res_slot_next   = '0;
                    res_status_next = ssba_pkg::STATUS_FULL;
                    state_next      = ST_RESP;
                end
                else
                begin
                    chk_addr_next  = scan_addr_reg;
                    scan_addr_next = next_waddr(scan_addr_reg);
                    chk_cnt_next   = chk_cnt_reg + 1'b1;
                end
            end

            ST_FREE_CHK:
            begin
                if (cur_word[req_bit])
                begin
                    wr_en           = 1'b1;
                    wr_data         = cur_word & ~(ssba_pkg::WORD_BITS'(1) << req_bit);
                    used_total_next = (used_total_reg != '0) ? used_total_reg - 1'b1
                                                             : used_total_reg;
                    if (res_slot_reg < search_hint_reg)
                    begin
                        search_hint_next = res_slot_reg;
                    end
                    res_status_next = ssba_pkg::STATUS_OK;
                end
                else
                begin
                    res_status_next = ssba_pkg::STATUS_NOTUSED;
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // load the output register once it is empty or draining
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = res_status_reg;
                    out_item_next.slot_out    = res_slot_reg;
                    out_item_next.used_count  = used_total_reg;
                    out_item_next.sector_out  =
                        (res_alloc_reg && res_status_reg == ssba_pkg::STATUS_OK)
                        ? sector_base_reg
                          + ssba_pkg::SECTOR_W'(res_slot_reg)
                          * ssba_pkg::SECTOR_W'(ssba_pkg::SECTORS_PER_SLOT)
                        : '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sector_base_reg <= ssba_pkg::SECTOR_BASE_RESET;
            used_total_reg  <= '0;
            search_hint_reg <= '0;
            row_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
            chk_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            used_total_reg  <= used_total_next;
            search_hint_reg <= search_hint_next;
            out_valid_reg   <= out_valid_next;
            chk_cnt_reg     <= chk_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                sector_base_reg <= cfg_data;
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        scan_addr_reg  <= scan_addr_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_alloc_reg  <= res_alloc_next;
        out_item_reg   <= out_item_next;
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= map_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
    end

    // count never exceeds the pool
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_total_reg <= ssba_pkg::COUNT_W'(ssba_pkg::NUM_SLOTS))
        else $error("used count beyond pool size");

    // bitmap is written only while a request is checked
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SCAN || state_reg == ST_FREE_CHK))
        else $error("bitmap write outside check states");

    // the scan ends within one full lap of the map
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> chk_cnt_reg <= ssba_pkg::SCAN_W'(ssba_pkg::MAP_WORDS))
        else $error("scan ran past one lap");

    // the hint moves only on a successful check
    a_hint_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(search_hint_reg) |-> $past(wr_en))
        else $error("hint changed without a bitmap update");

    // an allocate that succeeds raises the count by one
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && ff_found) |=> used_total_reg == $past(used_total_reg) + 1'b1)
        else $error("allocate did not bump the count");

endmodule

FILE: test/swap_slot_bitmap_allocator_tb.sv
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_tb
// self-checking testbench for the next-fit swap slot allocator: a predictor
// keeps its own bitmap, used count, search hint and sector base, works out
// the result of every accepted request and compares it field by field with
// what the block returns, with request gaps and result stalls on its channels
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // generous cycle budget for roughly 1.4k requests
    localparam int CYCLE_LIMIT = 400000;

    logic                          clk = 1'b0;
    logic                          rst_n;

    logic                          in_valid;
    logic                          in_stall;
    ssba_pkg::in_item_t            in_item;

    logic                          out_valid;
    logic                          out_stall = 1'b0;
    ssba_pkg::out_item_t           out_item;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ssba_pkg::SECTOR_W-1:0] cfg_data;

    // predictor state: one bit per slot, set while the slot is in use
    logic [ssba_pkg::NUM_SLOTS-1:0] slot_busy  = '0;
    int unsigned                    busy_count = 0;
    int unsigned                    next_hint  = 0;
    logic [ssba_pkg::SECTOR_W-1:0]  base_model = ssba_pkg::SECTOR_BASE_RESET;

    // results predicted at acceptance, oldest first
    ssba_pkg::out_item_t  pending_results[$];

    // run bookkeeping
    int unsigned          error_count    = 0;
    int unsigned          requests_sent  = 0;
    int unsigned          results_seen   = 0;
    int unsigned          base_writes    = 0;
    int unsigned          status_tally[4] = '{default: 0};
    int unsigned          cycle_count    = 0;
    int unsigned          stall_left     = 0;
    bit                   no_idle        = 1'b0;

    swap_slot_bitmap_allocator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("[swap_slot_bitmap_allocator] ERROR");
            $finish;
        end
    end

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // next-fit prediction of one accepted request, updates the shadow state
    task automatic predict_slot_result(input ssba_pkg::in_item_t req);
        ssba_pkg::out_item_t want;
        int unsigned         s;
        want = '0;
        if (req.cmd == ssba_pkg::CMD_ALLOC)
        begin
            if (busy_count >= ssba_pkg::NUM_SLOTS)
            begin
                want.status = ssba_pkg::STATUS_FULL;
            end
            else
            begin
                // a free slot must exist, so the circular scan terminates
                s = next_hint;
                while (slot_busy[s])
                    s = (s + 1) % ssba_pkg::NUM_SLOTS;
                slot_busy[s]    = 1'b1;
                busy_count++;
                next_hint       = (s + 1) % ssba_pkg::NUM_SLOTS;
                want.status     = ssba_pkg::STATUS_OK;
                want.slot_out   = ssba_pkg::SLOT_W'(s);
                // sector sum wraps at 32 bits
                want.sector_out = base_model
                                  + ssba_pkg::SECTOR_W'(s * ssba_pkg::SECTORS_PER_SLOT);
            end
        end
        else
        begin
            want.slot_out = req.slot_in;
            if (req.slot_in >= ssba_pkg::NUM_SLOTS)
            begin
                want.status = ssba_pkg::STATUS_RANGE;
            end
            else if (!slot_busy[req.slot_in])
            begin
                want.status = ssba_pkg::STATUS_NOTUSED;
            end
            else
            begin
                slot_busy[req.slot_in] = 1'b0;
                busy_count--;
                // freeing below the hint pulls the hint back down
                if (req.slot_in < next_hint)
                    next_hint = req.slot_in;
                want.status = ssba_pkg::STATUS_OK;
            end
        end
        want.used_count = ssba_pkg::COUNT_W'(busy_count);
        pending_results.push_back(want);
    endtask

    // result side: random stall per result, every accepted result checked
    always @(posedge clk)
    begin : result_monitor
        ssba_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            status_tally[out_item.status]++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, slot", out_item.slot_out, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                    report_mismatch("status", out_item.status, want.status);
                if (out_item.slot_out !== want.slot_out)
                    report_mismatch("slot_out", out_item.slot_out, want.slot_out);
                if (out_item.sector_out !== want.sector_out)
                    report_mismatch("sector_out", out_item.sector_out, want.sector_out);
                if (out_item.used_count !== want.used_count)
                    report_mismatch("used_count", out_item.used_count, want.used_count);
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 7);
        end
        else if (out_valid && stall_left != 0)
        begin
            // only count down while a result is actually held back
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    // offer one item after a random gap, return at the accepting edge;
    // valid stays high so a back-to-back item needs no drop in between
    task automatic send_request(input logic cmd, input logic [ssba_pkg::SLOT_W-1:0] slot);
        int unsigned        gap;
        ssba_pkg::in_item_t req;
        gap         = no_idle ? 0 : $urandom_range(0, 7);
        req.cmd     = cmd;
        req.slot_in = slot;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        predict_slot_result(req);
        requests_sent++;
    endtask

    // stop offering items and wait until every result has come back
    task automatic wait_for_drain(input int unsigned settle);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_sector_base(input logic [ssba_pkg::SECTOR_W-1:0] value);
        wait_for_drain(4);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        base_model = value;
        base_writes++;
    endtask

    // pick a slot that is in use, starting from a random point
    function automatic logic [ssba_pkg::SLOT_W-1:0] pick_busy_slot();
        int unsigned s;
        s = $urandom_range(0, ssba_pkg::NUM_SLOTS - 1);
        while (!slot_busy[s])
            s = (s + 1) % ssba_pkg::NUM_SLOTS;
        return ssba_pkg::SLOT_W'(s);
    endfunction

    // first allocations after reset, hint pull-back, double free, top slot
    task automatic test_basic_alloc_free();
        repeat (3) send_request(ssba_pkg::CMD_ALLOC, '1);     // slots 0..2, base 8192
        send_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'(1));  // hint drops to 1
        send_request(ssba_pkg::CMD_ALLOC, '0);                 // reuses slot 1
        send_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'(1));
        send_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'(1));  // already free
        send_request(ssba_pkg::CMD_FREE, '1);                  // top slot never used
        send_request(ssba_pkg::CMD_FREE, '0);
        send_request(ssba_pkg::CMD_ALLOC, ssba_pkg::SLOT_W'(10'h2AA)); // slot field ignored
        send_request(ssba_pkg::CMD_ALLOC, ssba_pkg::SLOT_W'(10'h155));
    endtask

    // sector arithmetic at the ends of the base range, including wrap
    task automatic test_sector_base_extremes();
        write_sector_base('1);
        repeat (2) send_request(ssba_pkg::CMD_ALLOC, '0);
        write_sector_base(32'hFFFF_FFF8);
        send_request(ssba_pkg::CMD_ALLOC, '0);
        write_sector_base('0);
        repeat (2) send_request(ssba_pkg::CMD_ALLOC, '0);
        send_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'(2));
        send_request(ssba_pkg::CMD_ALLOC, '0);
    endtask

    // fill every slot, then keep asking: full pool, wrapped search, refill
    task automatic test_pool_exhaustion();
        int unsigned need;
        write_sector_base($urandom);
        need = ssba_pkg::NUM_SLOTS - busy_count;
        repeat (need + 3) send_request(ssba_pkg::CMD_ALLOC, ssba_pkg::SLOT_W'($urandom));
        send_request(ssba_pkg::CMD_FREE, '1);
        send_request(ssba_pkg::CMD_FREE, '0);
        send_request(ssba_pkg::CMD_FREE, '0);                  // already free
        repeat (3) send_request(ssba_pkg::CMD_ALLOC, ssba_pkg::SLOT_W'($urandom));
    endtask

    // mixed traffic: alloc_pct percent allocations; frees mostly of live slots, some of random slots
    task automatic test_random_traffic(input int unsigned count, input int unsigned alloc_pct,
                                       input logic [ssba_pkg::SECTOR_W-1:0] base,
                                       input bit burst);
        logic                        cmd;
        logic [ssba_pkg::SLOT_W-1:0] slot;
        write_sector_base(base);
        no_idle = burst;
        repeat (count)
        begin
            cmd  = ssba_pkg::CMD_ALLOC;
            slot = ssba_pkg::SLOT_W'($urandom);
            if ($urandom_range(0, 99) >= alloc_pct)
            begin
                cmd = ssba_pkg::CMD_FREE;
                if (busy_count != 0 && $urandom_range(0, 9) < 8)
                    slot = pick_busy_slot();
            end
            send_request(cmd, slot);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_alloc_free();
        test_sector_base_extremes();
        test_pool_exhaustion();
        // pool starts full: drain, hover around full, then churn
        test_random_traffic(120, 20, $urandom, 1'b0);
        test_random_traffic(60, 55, $urandom, 1'b1);
        test_random_traffic(110, 65, '1, 1'b0);
        test_random_traffic(110, 45, ssba_pkg::SECTOR_BASE_RESET, 1'b0);

        wait_for_drain(25);

        $display("%0d requests, %0d results checked in %0d cycles, %0d base writes",
                 requests_sent, results_seen, cycle_count, base_writes);
        $display("status seen: ok %0d, full %0d, range %0d, not in use %0d, errors %0d",
                 status_tally[ssba_pkg::STATUS_OK], status_tally[ssba_pkg::STATUS_FULL],
                 status_tally[ssba_pkg::STATUS_RANGE], status_tally[ssba_pkg::STATUS_NOTUSED],
                 error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[swap_slot_bitmap_allocator] OK");
        else
            $display("[swap_slot_bitmap_allocator] ERROR");
        $finish;
    end

endmodule
